### sv/arpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg
// Types and constants shared by the address resolution cache modules.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int IpW     = 32;
    localparam int MacW    = 48;
    localparam int TimeW   = 32;
    localparam int EntryW  = IpW + MacW + TimeW;
    localparam int SlotW   = 3;
    localparam int DataW   = 32;
    localparam int AddrW   = 4;
    localparam int DefEntries = 8;

    localparam logic [TimeW-1:0] TimeMax = 32'hFFFF_FFFF;

    localparam logic OpLearn   = 1'b0;
    localparam logic OpResolve = 1'b1;

    localparam logic [1:0] RegOwnIp   = 2'd0;
    localparam logic [1:0] RegMask    = 2'd1;
    localparam logic [1:0] RegGateway = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic            found;
        logic            all_valid;
        logic [MacW-1:0] match_mac;
    } scan_stat_t;

endpackage

### sv/arpc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/arpc_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_scan
// Compare unit that inspects one cache entry per cycle while en is high and
// keeps the first match, the first free slot and the oldest valid entry.
// ----------------------------------------------------------------------------
module arpc_scan #(
    parameter int IW = 3
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  logic                      en,
    input  logic [IW-1:0]             idx,
    input  logic                      ent_valid,
    input  logic [arpc_pkg::IpW-1:0]   ent_ip,
    input  logic [arpc_pkg::MacW-1:0]  ent_mac,
    input  logic [arpc_pkg::TimeW-1:0] ent_time,
    input  logic [arpc_pkg::IpW-1:0]   target,
    output arpc_pkg::scan_stat_t      stat,
    output logic [IW-1:0]             match_idx,
    output logic [IW-1:0]             victim_idx
);

    logic                       found_reg, found_next;
    logic                       free_reg, free_next;
    logic [IW-1:0]              match_idx_reg, match_idx_next;
    logic [IW-1:0]              free_idx_reg, free_idx_next;
    logic [IW-1:0]              best_idx_reg, best_idx_next;
    logic [arpc_pkg::MacW-1:0]  mac_reg, mac_next;
    logic [arpc_pkg::TimeW-1:0] best_reg, best_next;

    always_comb
    begin
        found_next     = found_reg;
        free_next      = free_reg;
        match_idx_next = match_idx_reg;
        free_idx_next  = free_idx_reg;
        best_idx_next  = best_idx_reg;
        mac_next       = mac_reg;
        best_next      = best_reg;
        if (clear)
        begin
            found_next    = 1'b0;
            free_next     = 1'b0;
            best_next     = arpc_pkg::TimeMax;
            best_idx_next = '0;
        end
        else if (en)
        begin
            if (ent_valid && ent_ip == target && !found_reg)
            begin
                found_next     = 1'b1;
                match_idx_next = idx;
                mac_next       = ent_mac;
            end
            if (!ent_valid && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = idx;
            end
            if (ent_valid && ent_time < best_reg)
            begin
                best_next     = ent_time;
                best_idx_next = idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg    <= 1'b0;
            free_reg     <= 1'b0;
            best_idx_reg <= '0;
        end
        else
        begin
            found_reg    <= found_next;
            free_reg     <= free_next;
            best_idx_reg <= best_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        mac_reg       <= mac_next;
        best_reg      <= best_next;
    end

    assign stat.found     = found_reg;
    assign stat.all_valid = !free_reg;
    assign stat.match_mac = mac_reg;
    assign match_idx      = match_idx_reg;
    assign victim_idx     = free_reg ? free_idx_reg : best_idx_reg;

endmodule

### sv/arp_cache_resolve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_cache_resolve
// IPv4 to MAC address cache that fills free slots first, then replaces the
// oldest entry, with gateway lookup.
// The input channel carries learn and resolve requests; the output channel
// returns one result transfer per request. Both use valid and stall.
// A request is taken only while the block is idle. The table lives in a RAM
// that is read one entry per cycle, and a single compare unit checks each
// entry. A learn then writes the entry in ST_WRITE. The result is loaded
// into the output register in ST_DONE, and the next request can be taken
// in the cycle after that load. The result sits in an output register, so
// a new request may be taken while it waits; if the receiver is still
// stalling when the next result is ready, the block holds that result until
// the register frees. Reset clears every valid bit and the address registers
// at once, so no clearing pass is needed. The address registers are written
// over the APB port; the user must write them only while the block is idle,
// which the block itself does not enforce.
// ----------------------------------------------------------------------------
module arp_cache_resolve #(
    parameter int ENTRIES = arpc_pkg::DefEntries
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [arpc_pkg::AddrW-1:0]  paddr,
    input  logic [arpc_pkg::DataW-1:0]  pwdata,
    output logic [arpc_pkg::DataW-1:0]  prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       op,
    input  logic [arpc_pkg::IpW-1:0]    query_ip,
    input  logic [arpc_pkg::MacW-1:0]   new_mac,
    input  logic [arpc_pkg::TimeW-1:0]  now_ms,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       hit,
    output logic [arpc_pkg::MacW-1:0]   found_mac,
    output logic [arpc_pkg::IpW-1:0]    lookup_ip,
    output logic [arpc_pkg::SlotW-1:0]  slot,
    output logic                       evicted
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    arpc_pkg::state_t state_reg, state_next;

    logic [arpc_pkg::IpW-1:0]   own_ip_reg, mask_reg, gateway_reg;
    logic [ENTRIES-1:0]         valid_reg, valid_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic                       pend_reg, pend_next;
    logic [IW-1:0]              pidx_reg;

    logic                       op_reg;
    logic [arpc_pkg::IpW-1:0]   target_reg;
    logic [arpc_pkg::MacW-1:0]  mac_reg;
    logic [arpc_pkg::TimeW-1:0] now_reg;
    logic [arpc_pkg::IpW-1:0]   target_in;

    logic                       accept, cfg_wr, rd_en, we, load, scan_clear;
    logic [IW-1:0]              waddr, match_idx, victim_idx;
    logic [arpc_pkg::EntryW-1:0] rdata, wdata;
    arpc_pkg::scan_stat_t       stat;

    logic                       out_valid_reg, out_valid_next;
    logic                       hit_reg;
    logic [arpc_pkg::MacW-1:0]  fmac_reg;
    logic [arpc_pkg::IpW-1:0]   tip_reg;
    logic [arpc_pkg::SlotW-1:0] slot_reg;
    logic                       ev_reg;

    // Configuration registers.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg  <= '0;
            mask_reg    <= '0;
            gateway_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                arpc_pkg::RegOwnIp:   own_ip_reg  <= pwdata;
                arpc_pkg::RegMask:    mask_reg    <= pwdata;
                arpc_pkg::RegGateway: gateway_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            arpc_pkg::RegOwnIp:   prdata = own_ip_reg;
            arpc_pkg::RegMask:    prdata = mask_reg;
            arpc_pkg::RegGateway: prdata = gateway_reg;
            default:              prdata = '0;
        endcase
    end

    // Request capture.
    assign in_stall = (state_reg != arpc_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        target_in = query_ip;
        if (op == arpc_pkg::OpResolve
            && (own_ip_reg & mask_reg) != (query_ip & mask_reg))
        begin
            target_in = gateway_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op;
            target_reg <= target_in;
            mac_reg    <= new_mac;
            now_reg    <= now_ms;
        end
        if (rd_en)
        begin
            pidx_reg <= cnt_reg[IW-1:0];
        end
    end

    // Sequencer.
    assign rd_en = (state_reg == arpc_pkg::ST_SCAN) && (cnt_reg < CW'(ENTRIES));
    assign waddr = stat.found ? match_idx : victim_idx;
    assign wdata = {target_reg, mac_reg, now_reg};

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = rd_en;
        valid_next     = valid_reg;
        scan_clear     = 1'b0;
        we             = 1'b0;
        load           = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            arpc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = arpc_pkg::ST_SCAN;
                    cnt_next   = '0;
                    scan_clear = 1'b1;
                end
            end
            arpc_pkg::ST_SCAN:
            begin
                if (rd_en)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                else if (op_reg == arpc_pkg::OpLearn)
                begin
                    state_next = arpc_pkg::ST_WRITE;
                end
                else
                begin
                    state_next = arpc_pkg::ST_DONE;
                end
            end
            arpc_pkg::ST_WRITE:
            begin
                we                = 1'b1;
                valid_next[waddr] = 1'b1;
                state_next        = arpc_pkg::ST_DONE;
            end
            arpc_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load           = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = arpc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = arpc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= arpc_pkg::ST_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    arpc_ram #(
        .WIDTH (arpc_pkg::EntryW),
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (cnt_reg[IW-1:0]),
        .rdata (rdata)
    );

    arpc_scan #(
        .IW (IW)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (scan_clear),
        .en         (pend_reg),
        .idx        (pidx_reg),
        .ent_valid  (valid_reg[pidx_reg]),
        .ent_ip     (rdata[arpc_pkg::EntryW-1 -: arpc_pkg::IpW]),
        .ent_mac    (rdata[arpc_pkg::TimeW +: arpc_pkg::MacW]),
        .ent_time   (rdata[arpc_pkg::TimeW-1:0]),
        .target     (target_reg),
        .stat       (stat),
        .match_idx  (match_idx),
        .victim_idx (victim_idx)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hit_reg <= stat.found;
            tip_reg <= target_reg;
            if (op_reg == arpc_pkg::OpLearn)
            begin
                fmac_reg <= '0;
                slot_reg <= arpc_pkg::SlotW'(waddr);
                ev_reg   <= !stat.found && stat.all_valid;
            end
            else
            begin
                fmac_reg <= stat.found ? stat.match_mac : '0;
                slot_reg <= stat.found ? arpc_pkg::SlotW'(match_idx) : '0;
                ev_reg   <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign found_mac = fmac_reg;
    assign lookup_ip = tip_reg;
    assign slot      = slot_reg;
    assign evicted   = ev_reg;

    a_accept_scan : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == arpc_pkg::ST_SCAN)
        else $error("accepted request did not start a scan");

    a_cnt_range : assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(ENTRIES))
        else $error("scan counter beyond table depth");

    a_evict_miss : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> !hit)
        else $error("eviction reported on a hit");

    a_mac_hit : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found_mac != '0 |-> hit)
        else $error("MAC reported without a hit");

    a_write_learn : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == arpc_pkg::ST_WRITE |=> valid_reg != '0)
        else $error("table write left no valid entry");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the address resolution cache.
// ----------------------------------------------------------------------------
// Learn and resolve requests are sent over the input channel. A predictor
// keeps its own copy of the table and the address registers, and each result
// transfer is checked field by field against the oldest predicted reply.
// Directed requests cover an empty table, filling every slot, replacement of
// the oldest entry with ties and saturated time stamps, learn updates and
// gateway lookups for off-subnet targets. Random traffic then runs under
// several register settings, with random idle gaps on both channels and one
// long output hold-off that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module testbench;

    localparam int Slots      = arpc_pkg::DefEntries;
    localparam int Latency    = Slots + 4;
    localparam int HoldCycles = 400;
    localparam int QuietLimit = 4000;
    localparam int RandomPerPhase = 340;
    localparam logic [1:0] RegUnused = 2'd3;

    typedef struct packed {
        logic                       hit;
        logic [arpc_pkg::MacW-1:0]  mac;
        logic [arpc_pkg::IpW-1:0]   target;
        logic [arpc_pkg::SlotW-1:0] slot;
        logic                       evicted;
    } arp_reply_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [arpc_pkg::AddrW-1:0] paddr = '0;
    logic [arpc_pkg::DataW-1:0] pwdata = '0;
    logic [arpc_pkg::DataW-1:0] prdata;
    logic                       pready;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       op = 1'b0;
    logic [arpc_pkg::IpW-1:0]   query_ip = '0;
    logic [arpc_pkg::MacW-1:0]  new_mac = '0;
    logic [arpc_pkg::TimeW-1:0] now_ms = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       hit;
    logic [arpc_pkg::MacW-1:0]  found_mac;
    logic [arpc_pkg::IpW-1:0]   lookup_ip;
    logic [arpc_pkg::SlotW-1:0] slot;
    logic                       evicted;

    logic                       tbl_valid [Slots];
    logic [arpc_pkg::IpW-1:0]   tbl_ip    [Slots];
    logic [arpc_pkg::MacW-1:0]  tbl_mac   [Slots];
    logic [arpc_pkg::TimeW-1:0] tbl_stamp [Slots];
    logic [arpc_pkg::IpW-1:0]   cfg_own_ip = '0;
    logic [arpc_pkg::IpW-1:0]   cfg_mask = '0;
    logic [arpc_pkg::IpW-1:0]   cfg_gateway = '0;

    arp_reply_t                 awaited_replies [$];
    logic [arpc_pkg::IpW-1:0]   ip_pool [16];
    logic [arpc_pkg::TimeW-1:0] clock_ms = '0;

    int gap_pct = 0;
    int stall_pct = 0;
    int hold_order = 0;
    int errors = 0;
    int replies_seen = 0;
    int hits_sent = 0;
    int evictions_sent = 0;
    int redirects_sent = 0;
    int reg_writes = 0;

    arp_cache_resolve #(
        .ENTRIES(Slots)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .query_ip(query_ip),
        .new_mac(new_mac),
        .now_ms(now_ms),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .hit(hit),
        .found_mac(found_mac),
        .lookup_ip(lookup_ip),
        .slot(slot),
        .evicted(evicted)
    );

    always #2 clk = ~clk;

    function automatic int draw_idle_len();
        if ($urandom_range(15) == 0)
        begin
            return $urandom_range(80, 20);
        end
        return $urandom_range(3, 1);
    endfunction

    function automatic arp_reply_t predict_reply(
        input logic op_i,
        input logic [arpc_pkg::IpW-1:0] ip_i,
        input logic [arpc_pkg::MacW-1:0] mac_i,
        input logic [arpc_pkg::TimeW-1:0] now_i);
        arp_reply_t r;
        int k;
        int free;
        int oldest_idx;
        logic [arpc_pkg::TimeW-1:0] oldest;
        logic [arpc_pkg::IpW-1:0] look;
        r = '0;
        k = -1;
        look = ip_i;
        if (op_i == arpc_pkg::OpResolve
            && (cfg_own_ip & cfg_mask) != (ip_i & cfg_mask))
        begin
            look = cfg_gateway;
        end
        r.target = look;
        for (int i = 0; i < Slots; i++)
        begin
            if (k < 0 && tbl_valid[i] && tbl_ip[i] == look)
            begin
                k = i;
            end
        end
        if (op_i == arpc_pkg::OpResolve)
        begin
            if (k >= 0)
            begin
                r.hit = 1'b1;
                r.mac = tbl_mac[k];
                r.slot = k[arpc_pkg::SlotW-1:0];
            end
        end
        else
        begin
            if (k >= 0)
            begin
                r.hit = 1'b1;
            end
            else
            begin
                free = -1;
                oldest_idx = 0;
                oldest = arpc_pkg::TimeMax;
                for (int i = 0; i < Slots; i++)
                begin
                    if (!tbl_valid[i])
                    begin
                        if (free < 0)
                        begin
                            free = i;
                        end
                    end
                    else if (tbl_stamp[i] < oldest)
                    begin
                        oldest = tbl_stamp[i];
                        oldest_idx = i;
                    end
                end
                k = (free >= 0) ? free : oldest_idx;
                r.evicted = tbl_valid[k];
                tbl_valid[k] = 1'b1;
                tbl_ip[k] = ip_i;
            end
            tbl_mac[k] = mac_i;
            tbl_stamp[k] = now_i;
            r.slot = k[arpc_pkg::SlotW-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        if (errors <= 40)
        begin
            $display("%0t: reply %0d, %s: got %h, expected %h",
                     $realtime, replies_seen, what, got, want);
        end
    endtask

    task automatic check_reply();
        arp_reply_t want;
        if (awaited_replies.size() == 0)
        begin
            report_mismatch("unexpected transfer", 64'(lookup_ip), 64'd0);
            return;
        end
        want = awaited_replies.pop_front();
        if (hit !== want.hit)
        begin
            report_mismatch("hit", 64'(hit), 64'(want.hit));
        end
        if (found_mac !== want.mac)
        begin
            report_mismatch("found_mac", 64'(found_mac), 64'(want.mac));
        end
        if (lookup_ip !== want.target)
        begin
            report_mismatch("lookup_ip", 64'(lookup_ip), 64'(want.target));
        end
        if (slot !== want.slot)
        begin
            report_mismatch("slot", 64'(slot), 64'(want.slot));
        end
        if (evicted !== want.evicted)
        begin
            report_mismatch("evicted", 64'(evicted), 64'(want.evicted));
        end
        replies_seen++;
    endtask

    always @(posedge clk)
    begin : receiver
        int stall_run;
        int hold_seen;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            check_reply();
        end
        if (hold_seen != hold_order)
        begin
            hold_seen = hold_order;
            stall_run = HoldCycles;
        end
        if (stall_run > 0)
        begin
            stall_run--;
            out_stall <= 1'b1;
        end
        else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
        begin
            stall_run = draw_idle_len() - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : watchdog
        int quiet;
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        begin
            quiet = 0;
        end
        else
        begin
            quiet++;
        end
        if (quiet >= QuietLimit)
        begin
            $display("Timed out after %0d cycles without a transfer.", quiet);
            $display("FAIL arp_cache_resolve");
            $finish;
        end
    end

    task automatic apb_write(input logic [1:0] idx,
                             input logic [arpc_pkg::DataW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= arpc_pkg::AddrW'({idx, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        case (idx)
            arpc_pkg::RegOwnIp:   cfg_own_ip = value;
            arpc_pkg::RegMask:    cfg_mask = value;
            arpc_pkg::RegGateway: cfg_gateway = value;
            default:              ;
        endcase
        reg_writes++;
    endtask

    task automatic send_request(input logic op_i,
                                input logic [arpc_pkg::IpW-1:0] ip_i,
                                input logic [arpc_pkg::MacW-1:0] mac_i,
                                input logic [arpc_pkg::TimeW-1:0] now_i);
        arp_reply_t want;
        int gap;
        in_valid <= 1'b1;
        op <= op_i;
        query_ip <= ip_i;
        new_mac <= mac_i;
        now_ms <= now_i;
        do @(posedge clk); while (in_stall !== 1'b0);
        want = predict_reply(op_i, ip_i, mac_i, now_i);
        awaited_replies.push_back(want);
        hits_sent += want.hit;
        evictions_sent += want.evicted;
        if (op_i == arpc_pkg::OpResolve && want.target != ip_i)
        begin
            redirects_sent++;
        end
        gap = 0;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            gap = draw_idle_len();
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (awaited_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (Latency) @(posedge clk);
    endtask

    function automatic logic [arpc_pkg::MacW-1:0] random_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic test_empty_table();
        send_request(arpc_pkg::OpResolve, 32'h0000_0000, '0, '0);
        send_request(arpc_pkg::OpResolve, 32'hFFFF_FFFF, '1, '1);
        settle();
        apb_write(RegUnused, 32'hFFFF_FFFF);
    endtask

    task automatic test_fill_and_replace();
        logic [arpc_pkg::IpW-1:0] addr;
        logic [arpc_pkg::MacW-1:0] mac;
        for (int i = 0; i < Slots; i++)
        begin
            addr = 32'h0A00_0010 + i;
            mac = random_mac();
            if (i == 0)
            begin
                addr = 32'h0000_0000;
                mac = '0;
            end
            if (i == Slots - 1)
            begin
                addr = 32'hFFFF_FFFF;
                mac = '1;
            end
            send_request(arpc_pkg::OpLearn, addr, mac, arpc_pkg::TimeMax);
        end
        send_request(arpc_pkg::OpLearn, 32'h0A00_00AA, random_mac(), 32'd5);
        send_request(arpc_pkg::OpLearn, 32'h0A00_0013, random_mac(), 32'd0);
        send_request(arpc_pkg::OpLearn, 32'h0A00_00AB, random_mac(), 32'd100);
        send_request(arpc_pkg::OpLearn, 32'h0A00_0015, random_mac(), 32'd1);
        send_request(arpc_pkg::OpLearn, 32'h0A00_0012, random_mac(), 32'd1);
        send_request(arpc_pkg::OpLearn, 32'h0A00_00AC, random_mac(), 32'd50);
        send_request(arpc_pkg::OpResolve, 32'h0A00_0015, random_mac(), $urandom);
        send_request(arpc_pkg::OpResolve, 32'hFFFF_FFFF, random_mac(), $urandom);
        send_request(arpc_pkg::OpResolve, 32'h0A00_0012, random_mac(), $urandom);
        settle();
    endtask

    task automatic test_gateway_lookup();
        apb_write(arpc_pkg::RegOwnIp, 32'h0A00_0001);
        apb_write(arpc_pkg::RegMask, 32'hFFFF_FF00);
        apb_write(arpc_pkg::RegGateway, 32'h0A00_0015);
        send_request(arpc_pkg::OpResolve, 32'h0B00_0000, random_mac(), $urandom);
        send_request(arpc_pkg::OpResolve, 32'h0A00_00AA, random_mac(), $urandom);
        settle();
        apb_write(arpc_pkg::RegGateway, 32'h0A00_00FE);
        send_request(arpc_pkg::OpResolve, 32'hC0A8_0001, random_mac(), $urandom);
        settle();
    endtask

    task automatic build_pool();
        for (int i = 0; i < 16; i++)
        begin
            if (i < 8)
            begin
                ip_pool[i] = (cfg_own_ip & cfg_mask) | ($urandom & ~cfg_mask);
            end
            else if (i < 14)
            begin
                ip_pool[i] = $urandom;
            end
            else if (i == 14)
            begin
                ip_pool[i] = cfg_gateway;
            end
            else
            begin
                ip_pool[i] = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            end
        end
    endtask

    task automatic send_random_request();
        logic op_r;
        logic [arpc_pkg::IpW-1:0] addr;
        logic [arpc_pkg::TimeW-1:0] stamp;
        op_r = ($urandom_range(99) < 45) ? arpc_pkg::OpLearn : arpc_pkg::OpResolve;
        addr = ($urandom_range(99) < 85) ? ip_pool[$urandom_range(15)] : $urandom;
        case ($urandom_range(19))
            0:       stamp = arpc_pkg::TimeMax;
            1:       stamp = '0;
            2:       stamp = $urandom;
            default:
            begin
                clock_ms = clock_ms + $urandom_range(40);
                stamp = clock_ms;
            end
        endcase
        send_request(op_r, addr, random_mac(), stamp);
    endtask

    task automatic test_output_hold();
        gap_pct = 0;
        stall_pct = 0;
        build_pool();
        hold_order++;
        repeat (12) send_random_request();
        settle();
    endtask

    task automatic test_random_traffic();
        logic [arpc_pkg::IpW-1:0] own;
        logic [arpc_pkg::IpW-1:0] mask;
        logic [arpc_pkg::IpW-1:0] gw;
        int plen;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    own = 32'hC0A8_0105;
                    mask = 32'hFFFF_FF00;
                    gw = 32'hC0A8_01FE;
                end
                1:
                begin
                    own = 32'hFFFF_FFFF;
                    mask = 32'hFFFF_FFFF;
                    gw = 32'h0000_0000;
                end
                2:
                begin
                    own = 32'h0A00_0001;
                    mask = 32'hFF00_0000;
                    gw = 32'hFFFF_FFFF;
                end
                3:
                begin
                    plen = $urandom_range(32);
                    own = $urandom;
                    mask = (plen == 0) ? 32'h0 : 32'hFFFF_FFFF << (32 - plen);
                    gw = $urandom;
                end
                default:
                begin
                    own = 32'h0000_0000;
                    mask = 32'h0000_0000;
                    gw = $urandom;
                end
            endcase
            apb_write(arpc_pkg::RegOwnIp, own);
            apb_write(arpc_pkg::RegMask, mask);
            apb_write(arpc_pkg::RegGateway, gw);
            build_pool();
            for (int n = 0; n < RandomPerPhase; n++)
            begin
                if (n % 85 == 0)
                begin
                    case ((n / 85 + phase) % 4)
                        0:
                        begin
                            gap_pct = 0;
                            stall_pct = 0;
                        end
                        1:
                        begin
                            gap_pct = 30;
                            stall_pct = 30;
                        end
                        2:
                        begin
                            gap_pct = 10;
                            stall_pct = 60;
                        end
                        default:
                        begin
                            gap_pct = 60;
                            stall_pct = 10;
                        end
                    endcase
                end
                send_random_request();
            end
            settle();
        end
    endtask

    initial
    begin
        for (int i = 0; i < Slots; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_ip[i] = '0;
            tbl_mac[i] = '0;
            tbl_stamp[i] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        gap_pct = 20;
        stall_pct = 20;
        test_empty_table();
        test_fill_and_replace();
        test_gateway_lookup();
        test_output_hold();
        test_random_traffic();
        settle();
        $display("Checked %0d result transfers: %0d hits, %0d evictions, %0d via gateway.",
                 replies_seen, hits_sent, evictions_sent, redirects_sent);
        $display("Made %0d register writes and held the output off once for a long stretch.",
                 reg_writes);
        if (errors == 0)
        begin
            $display("PASS arp_cache_resolve");
        end
        else
        begin
            $display("FAIL arp_cache_resolve");
        end
        $finish;
    end

endmodule
